// ===== sv/mdm_pkg.sv =====
`default_nettype none
package mdm_pkg;

    localparam int NW        = 4;     // wheels: A left front, B right front, C left rear, D right rear
    localparam int SPD_W     = 7;     // clamped speed 0..100
    localparam int ABS_W     = 17;    // magnitude of a wheel sum
    localparam int NUM_W     = 24;    // magnitude * 100
    localparam int PIV_W     = 31;    // |a| * b for the side pivot
    localparam int DIV_BITS  = 7;     // quotient bits of the vector scaling
    localparam int FULL_SPEED = 100;
    localparam int PIV_SAT   = 10100; // |a|*b at or above this clamps to full speed
    localparam int RECIP     = 5243;  // 2^19 / 100, rounded up
    localparam int RECIP_SH  = 19;
    localparam logic [7:0] MIN_DUTY_RST = 8'd50;
    localparam logic [7:0] MAX_DUTY_RST = 8'd200;

    typedef enum logic [3:0] {
        OP_STOP     = 4'd0,
        OP_FWD      = 4'd1,
        OP_REV      = 4'd2,
        OP_STRAFE_L = 4'd3,
        OP_STRAFE_R = 4'd4,
        OP_TURN_L   = 4'd5,
        OP_TURN_R   = 4'd6,
        OP_SPIN_L   = 4'd7,
        OP_SPIN_R   = 4'd8,
        OP_PIVOT    = 4'd9,
        OP_CURVE    = 4'd10,
        OP_VECTOR   = 4'd11
    } t_op;

    typedef enum logic {
        CFG_MIN_DUTY = 1'b0,
        CFG_MAX_DUTY = 1'b1
    } t_cfg_idx;

    typedef logic [SPD_W-1:0] t_spd;

    // after the sums and the pivot product
    typedef struct packed {
        logic [3:0]                   op;
        logic [NW-1:0]                rev;
        logic [NW-1:0][SPD_W-1:0]     spd;
        logic [NW-1:0][ABS_W-1:0]     aw;
        logic [PIV_W-1:0]             piv;
    } t_s1;

    // through the scaling divider
    typedef struct packed {
        logic [3:0]                   op;
        logic [NW-1:0]                rev;
        logic [NW-1:0][SPD_W-1:0]     spd;
        logic [NW-1:0][NUM_W-1:0]     num;
        logic [ABS_W-1:0]             den;
        logic                         scale;
    } t_dv;

    // after the duty span product
    typedef struct packed {
        logic [3:0]                   op;
        logic [NW-1:0]                rev;
        logic [NW-1:0]                nz;
        logic [NW-1:0][16:0]          prod;
    } t_s3;

    function automatic t_spd clamp_spd(input logic [ABS_W-1:0] v);
        t_spd r;
        r = (v > ABS_W'(FULL_SPEED)) ? SPD_W'(FULL_SPEED) : v[SPD_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/mecanum_drive_mixer.sv =====
`default_nettype none
// Mecanum drive mixer: one motion request in, eight H-bridge duties out.
// A request passes the capture, sum, largest-sum, divider, duty span and output registers in turn to o_valid.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Reset (i_rst_n low, synchronous): all stage valid bits clear, min duty 50,
// max duty 200. The receiver cannot stall: each result shows for one cycle.
module mecanum_drive_mixer
    import mdm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [3:0]  i_opcode,
    input  wire logic [15:0] i_arg_a,
    input  wire logic [15:0] i_arg_b,
    input  wire logic [15:0] i_arg_c,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    output logic             o_valid,
    output logic [7:0]       o_duty_a1,
    output logic [7:0]       o_duty_a2,
    output logic [7:0]       o_duty_b1,
    output logic [7:0]       o_duty_b2,
    output logic [7:0]       o_duty_c1,
    output logic [7:0]       o_duty_c2,
    output logic [7:0]       o_duty_d1,
    output logic [7:0]       o_duty_d2
);

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // ---------------- configuration registers ----------------
    logic [7:0] r_min, r_max;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_DUTY_RST;
            r_max <= MAX_DUTY_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_DUTY: r_min <= i_cfg_data;
                CFG_MAX_DUTY: r_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage 0: capture the request ----------------
    // Drop opcodes past vector drive here: they never produce a result.
    logic        r_v0;
    logic [3:0]  r_op0;
    logic signed [15:0] r_a0, r_b0, r_c0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else          r_v0 <= start && (i_opcode <= OP_VECTOR);
        r_op0 <= i_opcode;
        r_a0  <= i_arg_a;
        r_b0  <= i_arg_b;
        r_c0  <= i_arg_c;
    end

    // ---------------- stage 1: wheel sums, directions, pivot product ----------------
    logic        r_v1;
    t_s1         r_s1, n_s1;
    always_comb begin
        logic signed [17:0] w [NW];
        logic [15:0] fa, fb;
        logic [14:0] bpos;
        logic        cp;
        t_spd        sa, sfa, sfb;
        w[0] = 18'(r_a0) + 18'(r_b0) + 18'(r_c0);
        w[1] = 18'(r_a0) - 18'(r_b0) - 18'(r_c0);
        w[2] = 18'(r_a0) - 18'(r_b0) + 18'(r_c0);
        w[3] = 18'(r_a0) + 18'(r_b0) - 18'(r_c0);
        // magnitudes fit unsigned even for the most negative input
        fa   = r_a0[15] ? 16'(-r_a0) : 16'(r_a0);
        fb   = r_b0[15] ? 16'(-r_b0) : 16'(r_b0);
        bpos = (!r_b0[15] && r_b0 != 16'sd0) ? r_b0[14:0] : 15'd0;
        cp   = !r_c0[15] && r_c0 != 16'sd0;
        sa   = r_a0[15] ? '0 : clamp_spd(ABS_W'(r_a0[14:0]));
        sfa  = clamp_spd(ABS_W'(fa));
        sfb  = clamp_spd(ABS_W'(fb));

        n_s1.op  = r_op0;
        n_s1.piv = PIV_W'(fa) * PIV_W'(bpos);
        for (int i = 0; i < NW; i++) begin
            n_s1.aw[i] = w[i][17] ? ABS_W'(-w[i]) : ABS_W'(w[i]);
            n_s1.spd[i] = sa;
        end
        n_s1.rev = '0;
        case (r_op0)
            OP_FWD:                n_s1.rev = 4'b0000;
            OP_REV:                n_s1.rev = 4'b1111;
            OP_STRAFE_L:           n_s1.rev = 4'b1001;   // bit0 = A .. bit3 = D
            OP_STRAFE_R:           n_s1.rev = 4'b0110;
            OP_TURN_L, OP_SPIN_L:  n_s1.rev = 4'b0101;
            OP_TURN_R, OP_SPIN_R:  n_s1.rev = 4'b1010;
            OP_PIVOT: begin
                // front pair at |a|; rear speeds fill in next stage
                n_s1.rev = {cp, !cp, cp, !cp};
                n_s1.spd[0] = sfa;
                n_s1.spd[1] = sfa;
                n_s1.spd[2] = '0;
                n_s1.spd[3] = '0;
            end
            OP_CURVE: begin
                n_s1.rev = {r_b0[15], r_a0[15], r_b0[15], r_a0[15]};
                n_s1.spd[0] = sfa;
                n_s1.spd[2] = sfa;
                n_s1.spd[1] = sfb;
                n_s1.spd[3] = sfb;
            end
            OP_VECTOR: begin
                for (int i = 0; i < NW; i++) begin
                    n_s1.rev[i] = w[i][17];
                    n_s1.spd[i] = '0;
                end
            end
            default: begin
                // stop
                for (int i = 0; i < NW; i++) n_s1.spd[i] = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= r_v0;
        r_s1 <= n_s1;
    end

    // ---------------- stage 2: largest sum, rear pivot speed ----------------
    t_dv  n_dv0;
    always_comb begin
        logic [ABS_W-1:0] m01, m23, m;
        logic [26:0]      rq;
        t_spd             rear;
        m01 = (r_s1.aw[0] > r_s1.aw[1]) ? r_s1.aw[0] : r_s1.aw[1];
        m23 = (r_s1.aw[2] > r_s1.aw[3]) ? r_s1.aw[2] : r_s1.aw[3];
        m   = (m01 > m23) ? m01 : m23;
        // divide by 100 with a reciprocal; exact below the clamp point
        rq   = 27'(r_s1.piv[13:0]) * 27'(RECIP);
        rear = (r_s1.piv >= PIV_W'(PIV_SAT)) ? SPD_W'(FULL_SPEED)
                                             : rq[RECIP_SH +: SPD_W];
        n_dv0.op    = r_s1.op;
        n_dv0.rev   = r_s1.rev;
        n_dv0.spd   = r_s1.spd;
        n_dv0.den   = m;
        n_dv0.scale = (r_s1.op == OP_VECTOR) && (m > ABS_W'(FULL_SPEED));
        for (int i = 0; i < NW; i++)
            n_dv0.num[i] = NUM_W'(r_s1.aw[i]) * NUM_W'(FULL_SPEED);
        if (r_s1.op == OP_PIVOT) begin
            n_dv0.spd[2] = rear;
            n_dv0.spd[3] = rear;
        end
        // without scaling the sums are already within full speed
        if (r_s1.op == OP_VECTOR && !n_dv0.scale)
            for (int i = 0; i < NW; i++) n_dv0.spd[i] = r_s1.aw[i][SPD_W-1:0];
    end

    // ---------------- stages 3..9: scaling divider, one quotient bit each ----------------
    logic [DIV_BITS:0] r_dvv;
    t_dv               r_dv [DIV_BITS+1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dvv[0] <= 1'b0;
        else          r_dvv[0] <= r_v1;
        r_dv[0] <= n_dv0;
    end

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
        localparam int BIT = DIV_BITS - 1 - k;
        t_dv n_dv;
        always_comb begin
            logic [NUM_W-1:0] dsh;
            n_dv = r_dv[k];
            dsh  = NUM_W'(r_dv[k].den) << BIT;
            if (r_dv[k].scale) begin
                for (int i = 0; i < NW; i++) begin
                    if (r_dv[k].num[i] >= dsh) begin
                        n_dv.num[i]      = r_dv[k].num[i] - dsh;
                        n_dv.spd[i][BIT] = 1'b1;
                    end
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dvv[k+1] <= 1'b0;
            else          r_dvv[k+1] <= r_dvv[k];
            r_dv[k+1] <= n_dv;
        end
    end

    // ---------------- stage 10: duty span times speed ----------------
    logic r_v3;
    t_s3  r_s3, n_s3;
    always_comb begin
        logic signed [8:0] diff;
        logic signed [7:0] sp;
        diff = $signed({1'b0, r_max}) - $signed({1'b0, r_min});
        n_s3.op  = r_dv[DIV_BITS].op;
        n_s3.rev = r_dv[DIV_BITS].rev;
        for (int i = 0; i < NW; i++) begin
            sp            = $signed({1'b0, r_dv[DIV_BITS].spd[i]});
            n_s3.nz[i]    = r_dv[DIV_BITS].spd[i] != '0;
            n_s3.prod[i]  = 17'(diff) * 17'(sp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_dvv[DIV_BITS];
        r_s3 <= n_s3;
    end

    // ---------------- stage 11: divide by 100, offset, pin mapping ----------------
    logic [NW-1:0][7:0] duty;
    logic [7:0]         n_pin [8];
    always_comb begin
        logic [15:0] mag;
        logic [28:0] qm;
        logic [7:0]  q;
        logic [9:0]  sd;
        logic        kill;
        for (int i = 0; i < NW; i++) begin
            // truncate toward zero: divide the magnitude, restore the sign
            mag = r_s3.prod[i][16] ? 16'(-r_s3.prod[i]) : 16'(r_s3.prod[i]);
            qm  = 29'(mag) * 29'(RECIP);
            q   = qm[RECIP_SH +: 8];
            sd  = {2'b0, r_min} + (r_s3.prod[i][16] ? 10'(-{2'b0, q}) : {2'b0, q});
            duty[i] = r_s3.nz[i] ? sd[7:0] : 8'd0;
        end
        // a side pivot whose front duty comes out zero stops every wheel
        kill = (r_s3.op == OP_PIVOT) && (duty[0] == 8'd0);
        // front wheels: pin 1 reverse, pin 2 forward; rear polarity is swapped
        n_pin[0] = ( r_s3.rev[0] && !kill) ? duty[0] : 8'd0;
        n_pin[1] = (!r_s3.rev[0] && !kill) ? duty[0] : 8'd0;
        n_pin[2] = ( r_s3.rev[1] && !kill) ? duty[1] : 8'd0;
        n_pin[3] = (!r_s3.rev[1] && !kill) ? duty[1] : 8'd0;
        n_pin[4] = (!r_s3.rev[2] && !kill) ? duty[2] : 8'd0;
        n_pin[5] = ( r_s3.rev[2] && !kill) ? duty[2] : 8'd0;
        n_pin[6] = (!r_s3.rev[3] && !kill) ? duty[3] : 8'd0;
        n_pin[7] = ( r_s3.rev[3] && !kill) ? duty[3] : 8'd0;
    end

    logic       r_vo;
    logic [7:0] r_pin [8];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vo <= 1'b0;
        else          r_vo <= r_v3;
        r_pin <= n_pin;
    end

    assign o_valid   = r_vo;
    assign o_duty_a1 = r_pin[0];
    assign o_duty_a2 = r_pin[1];
    assign o_duty_b1 = r_pin[2];
    assign o_duty_b2 = r_pin[3];
    assign o_duty_c1 = r_pin[4];
    assign o_duty_c2 = r_pin[5];
    assign o_duty_d1 = r_pin[6];
    assign o_duty_d2 = r_pin[7];

endmodule
`default_nettype wire

// ===== dv/tb_mecanum_drive_mixer.sv =====
`default_nettype none
module tb_mecanum_drive_mixer;
    import mdm_pkg::*;

    typedef struct {
        logic [3:0]  op;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
    } t_cmd;

    typedef struct {
        logic [7:0] d [8];
    } t_duties;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    wire         busy;
    logic [3:0]  i_opcode = '0;
    logic [15:0] i_arg_a = '0;
    logic [15:0] i_arg_b = '0;
    logic [15:0] i_arg_c = '0;
    logic        i_cfg_valid = 1'b0;
    wire         o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [7:0]  i_cfg_data = '0;
    wire         o_valid;
    wire [7:0]   o_duty_a1, o_duty_a2, o_duty_b1, o_duty_b2;
    wire [7:0]   o_duty_c1, o_duty_c2, o_duty_d1, o_duty_d2;

    mecanum_drive_mixer dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_arg_a(i_arg_a), .i_arg_b(i_arg_b), .i_arg_c(i_arg_c),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid),
        .o_duty_a1(o_duty_a1), .o_duty_a2(o_duty_a2), .o_duty_b1(o_duty_b1),
        .o_duty_b2(o_duty_b2), .o_duty_c1(o_duty_c1), .o_duty_c2(o_duty_c2),
        .o_duty_d1(o_duty_d1), .o_duty_d2(o_duty_d2)
    );

    always #5 i_clk = ~i_clk;

    // Mixer settings as the testbench believes them to be.
    int unsigned duty_lo = MIN_DUTY_RST;
    int unsigned duty_hi = MAX_DUTY_RST;

    t_cmd    pending_cmds [$];
    t_duties expected_duties [$];
    int      error_count = 0;
    bit      idle_ok = 1'b1;    // random sender gaps enabled
    bit      hold_sender = 1'b0;

    // Register write requests, handed to the config driver.
    logic        cfg_req = 1'b0;
    logic        cfg_req_idx;
    logic [7:0]  cfg_req_data;
    bit          cfg_done;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Map a percent speed to a duty with the current registers.
    function automatic int speed_duty(input int s);
        int lo, hi;
        lo = int'(duty_lo);
        hi = int'(duty_hi);
        if (s <= 0) return 0;
        if (s > 100) s = 100;
        return lo + (hi - lo) * s / 100;
    endfunction

    function automatic int sign_of(input int v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // Put one wheel's duty on its forward or reverse pin; rear wheels swap pins.
    function automatic void put_wheel(inout t_duties r, input int w, input int dir,
                                      input int duty);
        logic [7:0] v;
        logic [7:0] fwd, rv;
        v   = (dir == 0) ? 8'd0 : duty[7:0];
        fwd = (dir > 0) ? v : 8'd0;
        rv  = (dir < 0) ? v : 8'd0;
        if (w < 2) begin
            r.d[2*w] = rv;
            r.d[2*w+1] = fwd;
        end else begin
            r.d[2*w] = fwd;
            r.d[2*w+1] = rv;
        end
    endfunction

    // Compute the expected duties; return 0 when the opcode yields no result.
    function automatic bit mix_wheels(input t_cmd cmd, output t_duties r);
        int a, b, c, p, fa, fp, rp, dir, m, i;
        int w [4];
        int dirs [4];
        a = int'($signed(cmd.a));
        b = int'($signed(cmd.b));
        c = int'($signed(cmd.c));
        for (i = 0; i < 8; i++) r.d[i] = 8'd0;
        if (cmd.op > OP_VECTOR) return 1'b0;
        dirs = '{0, 0, 0, 0};
        case (t_op'(cmd.op))
            OP_FWD:                dirs = '{1, 1, 1, 1};
            OP_REV:                dirs = '{-1, -1, -1, -1};
            OP_STRAFE_L:           dirs = '{-1, 1, 1, -1};
            OP_STRAFE_R:           dirs = '{1, -1, -1, 1};
            OP_TURN_L, OP_SPIN_L:  dirs = '{-1, 1, -1, 1};
            OP_TURN_R, OP_SPIN_R:  dirs = '{1, -1, 1, -1};
            OP_PIVOT: begin
                fa = (a < 0) ? -a : a;
                fp = speed_duty(fa);
                rp = (b > 0) ? speed_duty(fa * b / 100) : 0;
                dir = (c > 0) ? 1 : -1;
                if (fp != 0) begin
                    put_wheel(r, 0, dir, fp);
                    put_wheel(r, 1, -dir, fp);
                    if (rp > 0) begin
                        put_wheel(r, 2, dir, rp);
                        put_wheel(r, 3, -dir, rp);
                    end
                end
            end
            OP_CURVE: begin
                p = speed_duty((a < 0) ? -a : a);
                put_wheel(r, 0, sign_of(a), p);
                put_wheel(r, 2, sign_of(a), p);
                p = speed_duty((b < 0) ? -b : b);
                put_wheel(r, 1, sign_of(b), p);
                put_wheel(r, 3, sign_of(b), p);
            end
            OP_VECTOR: begin
                w[0] = a + b + c;
                w[1] = a - b - c;
                w[2] = a - b + c;
                w[3] = a + b - c;
                m = 0;
                for (i = 0; i < 4; i++) if ((w[i] < 0 ? -w[i] : w[i]) > m)
                    m = (w[i] < 0) ? -w[i] : w[i];
                if (m > 100) for (i = 0; i < 4; i++) w[i] = w[i] * 100 / m;
                for (i = 0; i < 4; i++)
                    put_wheel(r, i, sign_of(w[i]), speed_duty((w[i] < 0) ? -w[i] : w[i]));
            end
            default: ;
        endcase
        if (cmd.op >= OP_FWD && cmd.op <= OP_SPIN_R) begin
            p = speed_duty(a);
            for (i = 0; i < 4; i++) put_wheel(r, i, dirs[i], p);
        end
        return 1'b1;
    endfunction

    // Driver: pop pending requests, idle at random, hold off when asked.
    always @(posedge i_clk) begin
        t_cmd    cmd;
        t_duties r;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            // retire the request taken at this edge
            if (start && !busy) begin
                cmd.op = i_opcode; cmd.a = i_arg_a; cmd.b = i_arg_b; cmd.c = i_arg_c;
                if (mix_wheels(cmd, r)) expected_duties.push_back(r);
                void'(pending_cmds.pop_front());
            end
            if (pending_cmds.size() > 0 && !hold_sender &&
                !(idle_ok && $urandom_range(99) < 33)) begin
                start    <= 1'b1;
                i_opcode <= pending_cmds[0].op;
                i_arg_a  <= pending_cmds[0].a;
                i_arg_b  <= pending_cmds[0].b;
                i_arg_c  <= pending_cmds[0].c;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Config driver: hold valid until the register is taken.
    always @(posedge i_clk) begin
        if (i_cfg_valid && o_cfg_ready) begin
            i_cfg_valid <= 1'b0;
            cfg_done = 1'b1;
        end else if (cfg_req && !cfg_done && !i_cfg_valid) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= cfg_req_idx;
            i_cfg_data  <= cfg_req_data;
        end
    end

    // Monitor: compare each strobed result with the oldest expectation.
    always @(posedge i_clk) begin
        t_duties exp_r;
        logic [7:0] got [8];
        if (i_rst_n && o_valid) begin
            got = '{o_duty_a1, o_duty_a2, o_duty_b1, o_duty_b2,
                    o_duty_c1, o_duty_c2, o_duty_d1, o_duty_d2};
            if (expected_duties.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                exp_r = expected_duties.pop_front();
                for (int i = 0; i < 8; i++)
                    if (got[i] !== exp_r.d[i])
                        report_mismatch($sformatf("duty pin %0d: got %0d, want %0d",
                                                  i, got[i], exp_r.d[i]));
            end
        end
    end

    task automatic push_cmd(input logic [3:0] op, input logic [15:0] a,
                            input logic [15:0] b, input logic [15:0] c);
        t_cmd cmd;
        cmd.op = op; cmd.a = a; cmd.b = b; cmd.c = c;
        pending_cmds.push_back(cmd);
    endtask

    // Wait for every request to be taken and every result to come back,
    // then let the pipeline drain of any no-result opcode still in flight.
    task automatic drain;
        while (pending_cmds.size() > 0 || start || expected_duties.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] val);
        cfg_req_idx  = idx;
        cfg_req_data = val;
        cfg_done     = 1'b0;
        cfg_req      = 1'b1;
        while (!cfg_done) @(posedge i_clk);
        cfg_req = 1'b0;
        if (idx == CFG_MIN_DUTY) duty_lo = val;
        else duty_hi = val;
    endtask

    // Random speeds: mostly around the useful range, sometimes anything.
    function automatic logic [15:0] rand_arg;
        case ($urandom_range(3))
            0:       return 16'($signed($urandom_range(240)) - 120);
            1:       return 16'($signed($urandom_range(20)) - 10);
            2:       return 16'($signed($urandom_range(2000)) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int count);
        logic [3:0] op;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 12))
                                          : 4'($urandom_range(11));
            push_cmd(op, rand_arg(), rand_arg(), rand_arg());
        end
    endtask

    initial begin
        int lo_set [5];
        int hi_set [5];
        lo_set = '{0, 255, 0, 200, 37};
        hi_set = '{255, 0, 0, 50, 181};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every opcode, field extremes, pivot and vector corners.
        for (int op = 0; op < 16; op++) push_cmd(4'(op), 16'sd100, 16'sd40, 16'sd5);
        push_cmd(OP_FWD, 16'h8000, 16'h7FFF, 16'hFFFF);   // negative simple speed
        push_cmd(OP_REV, 16'h7FFF, 16'h8000, 16'h0000);
        push_cmd(OP_PIVOT, 16'h8000, 16'h7FFF, 16'h7FFF);
        push_cmd(OP_PIVOT, 16'hFFCE, 16'hFFFF, 16'h0000);  // rear off, pivot left
        push_cmd(OP_PIVOT, 16'h0000, 16'd50, 16'd1);       // front duty zero
        push_cmd(OP_PIVOT, 16'd1, 16'd1, 16'd1);           // rear speed rounds to zero
        push_cmd(OP_CURVE, 16'hFFB0, 16'h0000, 16'h0000);
        push_cmd(OP_VECTOR, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        push_cmd(OP_VECTOR, 16'h8000, 16'h8000, 16'h8000);
        drain();

        // Long stretch with no sender gaps at reset settings.
        idle_ok = 1'b0;
        random_phase(200);
        drain();
        idle_ok = 1'b1;

        // Sweep register settings, extremes and inverted ones among them.
        for (int k = 0; k < 5; k++) begin
            write_reg(CFG_MIN_DUTY, 8'(lo_set[k]));
            write_reg(CFG_MAX_DUTY, 8'(hi_set[k]));
            random_phase(160);
            if (k == 2) begin
                // hold the sender until every expected result is back, then go on
                while (pending_cmds.size() > 80) @(posedge i_clk);
                hold_sender = 1'b1;
                @(posedge i_clk);
                while (start || expected_duties.size() > 0) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            drain();
        end
        write_reg(CFG_MIN_DUTY, 8'($urandom));
        write_reg(CFG_MAX_DUTY, 8'($urandom));
        random_phase(200);
        drain();

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

// ===== mecanum_drive_mixer.f =====
sv/mdm_pkg.sv
sv/mecanum_drive_mixer.sv
dv/tb_mecanum_drive_mixer.sv
